[hw/rtl/npc_pkg.sv]
// Package for the nearest palette color unit: widths, codes, types and the
// default terminal palette. Used by the interfaces, the cell and the top level.
package npc_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 256;
    localparam int unsigned COLOR_W         = 8;
    localparam int unsigned IDX_W           = 8;
    localparam int unsigned SQ_W            = 2 * COLOR_W;
    localparam int unsigned DIST_W          = SQ_W + 2;

    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [SQ_W-1:0]    t_sq;
    typedef logic [DIST_W-1:0]  t_dist;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        t_color red;
        t_color green;
        t_color blue;
    } t_rgb;

    typedef struct packed {
        logic clear;
        logic feed;
        t_idx index;
    } t_dist_ctl;

    localparam t_rgb ANSI16 [16] = '{
        24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
        24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF,
        24'h808080, 24'h800000, 24'h008000, 24'h808000,
        24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0
    };

    localparam t_color CUBE_LEVEL [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

    function automatic t_rgb default_entry(int unsigned index);
        t_rgb        rgb;
        int unsigned k;
        int unsigned v;
        k = 0;
        v = 0;
        if (index < 16) begin
            rgb = ANSI16[index[3:0]];
        end else if (index < 232) begin
            k         = index - 16;
            rgb.red   = CUBE_LEVEL[3'(k / 36)];
            rgb.green = CUBE_LEVEL[3'((k / 6) % 6)];
            rgb.blue  = CUBE_LEVEL[3'(k % 6)];
        end else begin
            v         = 8 + 10 * (index - 232);
            rgb.red   = COLOR_W'(v);
            rgb.green = COLOR_W'(v);
            rgb.blue  = COLOR_W'(v);
        end
        return rgb;
    endfunction

endpackage

[hw/rtl/npc_in_if.sv]
// Input channel of the nearest palette color unit: valid/ready and one item.
// Depends on npc_pkg.
interface npc_in_if;
    logic            valid;
    logic            ready;
    npc_pkg::t_cmd   cmd;
    npc_pkg::t_idx   entry_index;
    npc_pkg::t_color red;
    npc_pkg::t_color green;
    npc_pkg::t_color blue;

    modport source (output valid, cmd, entry_index, red, green, blue, input ready);
    modport sink   (input valid, cmd, entry_index, red, green, blue, output ready);
endinterface

[hw/rtl/npc_out_if.sv]
// Result channel of the nearest palette color unit: valid/ready and the index.
// Depends on npc_pkg.
interface npc_out_if;
    logic          valid;
    logic          ready;
    npc_pkg::t_idx nearest_index;

    modport source (output valid, nearest_index, input ready);
    modport sink   (input valid, nearest_index, output ready);
endinterface

[hw/rtl/npc_cell.sv]
// One palette cell of the ring: holds a single entry, loads on a write to its
// index, and takes its neighbor's entry on a shift. Depends on npc_pkg.
module npc_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic          i_wr,
    input  npc_pkg::t_idx i_wr_index,
    input  npc_pkg::t_rgb i_wr_rgb,
    input  npc_pkg::t_rgb i_next,
    output npc_pkg::t_rgb o_entry
);
    import npc_pkg::*;

    localparam t_rgb RESET_RGB = default_entry(INDEX);
    localparam t_idx MY_INDEX  = IDX_W'(INDEX);

    t_rgb r_entry;
    t_rgb n_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_shift) begin
            n_entry = i_next;
        end else if (i_wr && (i_wr_index == MY_INDEX)) begin
            n_entry = i_wr_rgb;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= RESET_RGB;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
endmodule

[hw/rtl/npc_dist.sv]
// Distance unit: squares the component differences of the ring head against
// the query color, then sums and keeps the first smallest. Depends on npc_pkg.
module npc_dist (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  npc_pkg::t_dist_ctl i_ctl,
    input  npc_pkg::t_rgb     i_query,
    input  npc_pkg::t_rgb     i_entry,
    output npc_pkg::t_idx     o_best_index
);
    import npc_pkg::*;

    function automatic t_color abs_diff(t_color a, t_color b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_color d_red;
    t_color d_green;
    t_color d_blue;
    t_dist  sum;

    t_sq   r_sq_red;
    t_sq   r_sq_green;
    t_sq   r_sq_blue;
    t_idx  r_sq_index;
    logic  r_sq_vld;
    t_dist r_best_dist;
    t_idx  r_best_index;

    assign d_red   = abs_diff(i_query.red,   i_entry.red);
    assign d_green = abs_diff(i_query.green, i_entry.green);
    assign d_blue  = abs_diff(i_query.blue,  i_entry.blue);

    assign sum = DIST_W'(r_sq_red) + DIST_W'(r_sq_green) + DIST_W'(r_sq_blue);

    always_ff @(posedge i_clk) begin
        r_sq_red   <= SQ_W'(d_red)   * SQ_W'(d_red);
        r_sq_green <= SQ_W'(d_green) * SQ_W'(d_green);
        r_sq_blue  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
        r_sq_index <= i_ctl.index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld     <= 1'b0;
            r_best_dist  <= '1;
            r_best_index <= '0;
        end else if (i_ctl.clear) begin
            r_sq_vld     <= 1'b0;
            r_best_dist  <= '1;
            r_best_index <= '0;
        end else begin
            r_sq_vld <= i_ctl.feed;
            if (r_sq_vld && (sum < r_best_dist)) begin
                r_best_dist  <= sum;
                r_best_index <= r_sq_index;
            end
        end
    end

    assign o_best_index = r_best_index;
endmodule

[hw/rtl/nearest_palette_color_unit.sv]
// Nearest palette color unit: ring of palette cells rotated past one
// distance unit, with a sequencer and a result register. Depends on npc_pkg,
// npc_in_if, npc_out_if, npc_cell and npc_dist.
//
//   channel   | dir | word
//   i_item    | in  | cmd, entry_index, red, green, blue
//   o_result  | out | nearest_index (one per query, none per write)
//
// A write lands in its cell directly.
// A query rotates the ring one cell per cycle past the distance unit,
// then its two stages drain before the result is registered.
// The next word is taken while a result still waits in the result register.
// A finished query holds in its last state while the result register is full.
// Reset loads the default terminal palette into the cells.
module nearest_palette_color_unit #(
    parameter int unsigned PALETTE_ENTRIES = npc_pkg::ENTRIES_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    npc_in_if.sink    i_item,
    npc_out_if.source o_result
);
    import npc_pkg::*;

    localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(PALETTE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    t_rgb             r_query;
    logic             r_out_vld;
    t_idx             r_out_idx;

    logic      accept;
    logic      wr;
    logic      shift;
    t_rgb      item_rgb;
    t_dist_ctl dist_ctl;
    t_idx      best_index;
    t_rgb      cell_entry [PALETTE_ENTRIES];

    assign accept   = i_item.valid && i_item.ready;
    assign wr       = accept && (i_item.cmd == CMD_WRITE);
    assign shift    = (r_state == S_SCAN);
    assign item_rgb = '{red: i_item.red, green: i_item.green, blue: i_item.blue};

    assign i_item.ready = (r_state == S_IDLE);

    genvar k;
    generate
        for (k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
            npc_cell #(
                .INDEX (k)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (shift),
                .i_wr       (wr),
                .i_wr_index (i_item.entry_index),
                .i_wr_rgb   (item_rgb),
                .i_next     (cell_entry[(k + 1) % PALETTE_ENTRIES]),
                .o_entry    (cell_entry[k])
            );
        end
    endgenerate

    assign dist_ctl.clear = accept && (i_item.cmd == CMD_QUERY);
    assign dist_ctl.feed  = shift;
    assign dist_ctl.index = IDX_W'(r_cnt);

    npc_dist u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (dist_ctl),
        .i_query      (r_query),
        .i_entry      (cell_entry[0]),
        .o_best_index (best_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_result.ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept && (i_item.cmd == CMD_QUERY)) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || o_result.ready) begin
                        r_out_vld <= 1'b1;
                        r_out_idx <= best_index;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_query <= item_rgb;
        end
    end

    assign o_result.valid         = r_out_vld;
    assign o_result.nearest_index = r_out_idx;
endmodule

[dv/tb_top.sv]
// Testbench for nearest_palette_color_unit: palette writes and nearest-color queries,
// checked against an in-bench palette copy with a linear nearest-index search.
// Depends on npc_pkg, npc_in_if, npc_out_if and the unit under test.
module tb_top;
    import npc_pkg::*;

    localparam int unsigned ENTRIES      = ENTRIES_DEFAULT;
    localparam int unsigned RANDOM_WORDS = 1230;
    localparam int unsigned PRESSURE_AT  = 500;
    localparam int unsigned QUIET_AT     = 1080;
    localparam int unsigned LONG_HOLD    = 1500;
    localparam int unsigned DRAIN_CYCLES = 300;

    class palette_scoreboard;
        t_rgb        palette [ENTRIES];
        t_idx        pending_nearest [$];
        int unsigned errors;
        int unsigned writes;
        int unsigned queries;
        int unsigned exact_hits;
        int unsigned checked;

        function new();
            t_rgb        ansi [16];
            t_color      lvl [6];
            int unsigned k;
            ansi = '{24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
                     24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF,
                     24'h808080, 24'h800000, 24'h008000, 24'h808000,
                     24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0};
            lvl  = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};
            for (int i = 0; i < 16; i++) palette[i] = ansi[i];
            k = 16;
            for (int r = 0; r < 6; r++)
                for (int g = 0; g < 6; g++)
                    for (int b = 0; b < 6; b++) begin
                        palette[k] = {lvl[r], lvl[g], lvl[b]};
                        k++;
                    end
            for (int i = 0; i < 24; i++)
                palette[232 + i] = {3{t_color'(8 + 10 * i)}};
        endfunction

        function t_idx nearest_of(t_rgb c);
            int unsigned best;
            int unsigned d;
            int unsigned dr;
            int unsigned dg;
            int unsigned db;
            t_idx        pick;
            best = 32'h7FFF_FFFF;
            pick = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                dr = (c.red > palette[i].red) ? c.red - palette[i].red
                                              : palette[i].red - c.red;
                dg = (c.green > palette[i].green) ? c.green - palette[i].green
                                                  : palette[i].green - c.green;
                db = (c.blue > palette[i].blue) ? c.blue - palette[i].blue
                                                : palette[i].blue - c.blue;
                d  = dr * dr + dg * dg + db * db;
                if (d < best) begin
                    best = d;
                    pick = t_idx'(i);
                end
            end
            if (best == 0) exact_hits++;
            return pick;
        endfunction

        function void note_word(t_cmd cmd, t_idx idx, t_rgb c);
            if (cmd == CMD_WRITE) begin
                writes++;
                if (idx < ENTRIES) palette[idx] = c;
            end else begin
                queries++;
                pending_nearest.push_back(nearest_of(c));
            end
        endfunction

        function void check_result(t_idx got);
            t_idx want;
            if (pending_nearest.size() == 0) begin
                $display("%0t: nearest index mismatch, expected none, actual %0d",
                         $time, got);
                errors++;
                return;
            end
            want = pending_nearest.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: nearest index mismatch, expected %0d, actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   stall_go;
    bit   quiet;

    palette_scoreboard sb = new();

    npc_in_if  item_ch ();
    npc_out_if result_ch ();

    nearest_palette_color_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_word(input t_cmd cmd, input t_idx idx, input t_rgb c);
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= cmd;
        item_ch.entry_index <= idx;
        item_ch.red         <= c.red;
        item_ch.green       <= c.green;
        item_ch.blue        <= c.blue;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sb.note_word(cmd, idx, c);
    endtask

    task automatic pause_input(input int unsigned cycles);
        item_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic random_word();
        t_rgb        c;
        t_idx        k;
        int unsigned pick;
        k    = t_idx'($urandom);
        c    = t_rgb'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            if ($urandom_range(0, 3) == 0) c = sb.palette[t_idx'($urandom)];
            send_word(CMD_WRITE, k, c);
        end else if (pick < 60) begin
            send_word(CMD_QUERY, k, c);
        end else if (pick < 80) begin
            send_word(CMD_QUERY, t_idx'($urandom), sb.palette[k]);
        end else begin
            c       = sb.palette[k];
            c.red   = c.red ^ t_color'($urandom_range(0, 3));
            c.green = c.green ^ t_color'($urandom_range(0, 3));
            c.blue  = c.blue ^ t_color'($urandom_range(0, 3));
            send_word(CMD_QUERY, t_idx'($urandom), c);
        end
    endtask

    // result sink: random back-pressure, one long hold on request
    initial begin
        bit held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (stall_go && !held) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.nearest_index);
    end

    initial begin
        item_ch.valid       <= 1'b0;
        item_ch.cmd         <= CMD_WRITE;
        item_ch.entry_index <= '0;
        item_ch.red         <= '0;
        item_ch.green       <= '0;
        item_ch.blue        <= '0;
        i_rst_n             <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_QUERY, 8'd0,   24'h000000);
        send_word(CMD_QUERY, 8'd255, 24'hFFFFFF);
        send_word(CMD_QUERY, 8'd0,   24'h808080);
        send_word(CMD_QUERY, 8'd0,   24'hC0C0C0);
        send_word(CMD_QUERY, 8'd0,   24'h7F0000);
        send_word(CMD_QUERY, 8'd0,   24'h00FF01);
        send_word(CMD_WRITE, 8'd0,   24'hFFFFFF);
        send_word(CMD_QUERY, 8'd0,   24'h000000);
        send_word(CMD_QUERY, 8'd0,   24'hFFFFFF);
        send_word(CMD_WRITE, 8'd255, 24'h000000);
        send_word(CMD_QUERY, 8'd0,   24'h000000);
        send_word(CMD_WRITE, 8'd0,   24'h000000);
        send_word(CMD_WRITE, 8'd200, 24'h101010);
        send_word(CMD_WRITE, 8'd201, 24'h121212);
        send_word(CMD_QUERY, 8'd0,   24'h111111);
        send_word(CMD_WRITE, 8'd250, 24'h123456);
        send_word(CMD_WRITE, 8'd251, 24'h123456);
        send_word(CMD_QUERY, 8'd0,   24'h123456);
        send_word(CMD_WRITE, 8'd170, 24'h555555);
        send_word(CMD_QUERY, 8'd85,  24'h555555);
        send_word(CMD_WRITE, 8'd85,  24'hAAAAAA);
        send_word(CMD_QUERY, 8'd170, 24'hAAAAAA);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == PRESSURE_AT) begin
                stall_go = 1'b1;
                for (int j = 0; j < 12; j++)
                    send_word(CMD_QUERY, t_idx'($urandom), t_rgb'($urandom));
            end
            if (n == QUIET_AT) quiet = 1'b1;
            random_word();
            if (!quiet && $urandom_range(0, 3) == 0)
                pause_input($urandom_range(1, 6));
        end
        item_ch.valid <= 1'b0;

        while (sb.pending_nearest.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d palette writes and %0d queries (%0d exact matches)",
                 sb.writes, sb.queries, sb.exact_hits);
        $display("checked %0d results, with ties, overwrites and a long output stall",
                 sb.checked);
        if (sb.errors == 0 && sb.pending_nearest.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/npc_pkg.sv
hw/rtl/npc_in_if.sv
hw/rtl/npc_out_if.sv
hw/rtl/npc_cell.sv
hw/rtl/npc_dist.sv
hw/rtl/nearest_palette_color_unit.sv
dv/tb_top.sv
